// File: src/tdlex_pkg.sv
`default_nettype none

package tdlex_pkg;

  // Fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned TYPE_W  = 4;

  // Default geometry of the action table
  localparam int unsigned STATES_DEF   = 16;
  localparam int unsigned ALPHABET_DEF = 256;

  // Column used for end of input, and the token type limit
  localparam logic [CHAR_W-1:0] EOF_CODE    = 8'd0;
  localparam int unsigned       TOKEN_TYPES = 16;

  typedef enum logic [1:0] {
    CMD_CHAR    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CA_ADD     = 2'd0,
    CA_PUTBACK = 2'd1,
    CA_IGNORE  = 2'd2,
    CA_ERROR   = 2'd3
  } char_act_e;

  typedef enum logic [1:0] {
    BA_KEEP   = 2'd0,
    BA_CLEAR  = 2'd1,
    BA_RETURN = 2'd2
  } buf_act_e;

  typedef struct packed {
    logic [1:0]         char_action;
    logic [1:0]         buffer_action;
    logic               set_type;
    logic [TYPE_W-1:0]  new_type;
    logic [STATE_W-1:0] next_state;
  } entry_t;

  localparam entry_t ERR_ENTRY = '{
    char_action:   CA_ERROR,
    buffer_action: BA_KEEP,
    set_type:      1'b0,
    new_type:      '0,
    next_state:    '0
  };

  typedef struct packed {
    logic              char_taken;
    logic              append_char;
    logic [CHAR_W-1:0] out_char;
    logic              clear_token;
    logic              token_done;
    logic [TYPE_W-1:0] token_type;
    logic              lex_error;
    logic              input_ended;
  } result_t;

endpackage

`default_nettype wire

// File: src/tdlex_table.sv
`default_nettype none

module tdlex_table #(
  parameter int unsigned STATES   = tdlex_pkg::STATES_DEF,
  parameter int unsigned ALPHABET = tdlex_pkg::ALPHABET_DEF,
  localparam int unsigned DEPTH   = STATES * ALPHABET,
  localparam int unsigned AW      = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire tdlex_pkg::entry_t wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output tdlex_pkg::entry_t      rd_data_o,
  output logic                   clr_busy_o
);

  tdlex_pkg::entry_t mem [DEPTH];
  tdlex_pkg::entry_t rd_data_q;

  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // Clearing pass: one entry per cycle after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= tdlex_pkg::ERR_ENTRY;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

// File: src/tdlex_step.sv
`default_nettype none

module tdlex_step (
  input  wire tdlex_pkg::entry_t                   entry_i,
  input  wire logic                                miss_i,
  input  wire logic [tdlex_pkg::CHAR_W-1:0]        char_i,
  input  wire logic                                eoi_i,
  input  wire logic [tdlex_pkg::TYPE_W-1:0]        cur_type_i,
  output tdlex_pkg::result_t                       res_o,
  output logic [tdlex_pkg::STATE_W-1:0]            next_state_o,
  output logic [tdlex_pkg::TYPE_W-1:0]             next_type_o
);

  tdlex_pkg::entry_t               ent;
  tdlex_pkg::result_t              res;
  logic [tdlex_pkg::TYPE_W-1:0]    typ;

  always_comb begin
    ent = miss_i ? tdlex_pkg::ERR_ENTRY : entry_i;
    typ = cur_type_i;
    res = '0;
    res.char_taken  = 1'b1;
    res.input_ended = eoi_i;
    next_state_o    = '0;

    if (ent.char_action == tdlex_pkg::CA_ERROR) begin
      res.lex_error   = 1'b1;
      res.clear_token = 1'b1;
      typ             = '0;
    end else begin
      case (ent.char_action)
        tdlex_pkg::CA_ADD: begin
          res.append_char = 1'b1;
          res.out_char    = char_i;
        end
        tdlex_pkg::CA_PUTBACK: begin
          res.char_taken = eoi_i;   // nothing to resend at end of input
        end
        default: ;
      endcase
      case (ent.buffer_action)
        tdlex_pkg::BA_CLEAR:  res.clear_token = 1'b1;
        tdlex_pkg::BA_RETURN: res.token_done  = 1'b1;
        default: ;
      endcase
      if (eoi_i) begin
        res.token_done = 1'b1;
      end
      if (ent.set_type) begin
        typ = ent.new_type;
      end
      next_state_o = ent.next_state;
    end

    res.token_type = typ;
    next_type_o    = res.token_done ? '0 : typ;
    res_o          = res;
  end

endmodule

`default_nettype wire

// File: src/table_driven_lexer_fsm.sv
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_stall_o  cmd, char_code, end_of_input, entry fields
// out      source     out_valid_o / out_stall_i lexer result flags, out_char, token_type
//
// A character transfer stalls the input until its result enters the output register:
// the action table read at the accept edge returns in the next cycle, and the next
// lookup needs the state that entry gives. Table writes and restarts give no result.
// After reset a clearing pass fills all STATES*ALPHABET entries (4096 by default) of
// the table with the error action; in_stall_o is high until it is done.
// The result sits in an output register, so a stalled output still lets one more
// character enter the lookup stage; that stage holds until the register frees.

module table_driven_lexer_fsm #(
  parameter int unsigned STATES   = tdlex_pkg::STATES_DEF,
  parameter int unsigned ALPHABET = tdlex_pkg::ALPHABET_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         cmd_i,
  input  wire logic [tdlex_pkg::CHAR_W-1:0]       char_code_i,
  input  wire logic                               end_of_input_i,
  input  wire logic [tdlex_pkg::STATE_W-1:0]      entry_state_i,
  input  wire logic [1:0]                         char_action_i,
  input  wire logic [1:0]                         buffer_action_i,
  input  wire logic                               set_type_i,
  input  wire logic [tdlex_pkg::TYPE_W-1:0]       new_type_i,
  input  wire logic [tdlex_pkg::STATE_W-1:0]      next_state_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    char_taken_o,
  output logic                                    append_char_o,
  output logic [tdlex_pkg::CHAR_W-1:0]            out_char_o,
  output logic                                    clear_token_o,
  output logic                                    token_done_o,
  output logic [tdlex_pkg::TYPE_W-1:0]            token_type_o,
  output logic                                    lex_error_o,
  output logic                                    input_ended_o
);

  localparam int unsigned DEPTH = STATES * ALPHABET;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Lexer state registers
  logic [tdlex_pkg::STATE_W-1:0] state_q;
  logic [tdlex_pkg::TYPE_W-1:0]  type_q;

  // Lookup stage: character waiting on the table read
  logic                          p_valid_q, p_valid_d;
  logic [tdlex_pkg::CHAR_W-1:0]  p_char_q;
  logic                          p_eoi_q;
  logic                          p_miss_q;

  // Output register
  logic                          out_valid_q, out_valid_d;
  tdlex_pkg::result_t            out_q;

  logic                          clr_busy;
  logic                          in_xfer, char_xfer, wr_xfer, rst_xfer;
  logic                          wr_ok, lookup_ok, p_done;
  logic [tdlex_pkg::CHAR_W-1:0]  col;
  logic [AW-1:0]                 rd_addr, wr_addr;
  tdlex_pkg::entry_t             wr_entry, rd_entry;
  tdlex_pkg::result_t            step_res;
  logic [tdlex_pkg::STATE_W-1:0] step_state;
  logic [tdlex_pkg::TYPE_W-1:0]  step_type;

  // One item at a time in the lookup stage; the next one needs its state
  assign in_stall_o = clr_busy | p_valid_q;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign char_xfer  = in_xfer & (cmd_i == tdlex_pkg::CMD_CHAR);
  assign wr_xfer    = in_xfer & (cmd_i == tdlex_pkg::CMD_WRITE) & wr_ok;
  assign rst_xfer   = in_xfer & (cmd_i == tdlex_pkg::CMD_RESTART);

  // Out-of-range writes are dropped
  assign wr_ok = (int'(char_code_i) < ALPHABET) && (int'(entry_state_i) < STATES) &&
                 (int'(next_state_i) < STATES) &&
                 (int'(new_type_i) < tdlex_pkg::TOKEN_TYPES);

  assign wr_addr = AW'(int'(entry_state_i) * ALPHABET + int'(char_code_i));
  assign wr_entry = '{
    char_action:   char_action_i,
    buffer_action: buffer_action_i,
    set_type:      set_type_i,
    new_type:      new_type_i,
    next_state:    next_state_i
  };

  // End of input looks up the EOF column
  assign col       = end_of_input_i ? tdlex_pkg::EOF_CODE : char_code_i;
  assign lookup_ok = (int'(col) < ALPHABET) && (int'(state_q) < STATES);
  assign rd_addr   = lookup_ok ? AW'(int'(state_q) * ALPHABET + int'(col)) : '0;

  tdlex_table #(
    .STATES   (STATES),
    .ALPHABET (ALPHABET)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_xfer),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_entry),
    .rd_en_i    (char_xfer),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_entry),
    .clr_busy_o (clr_busy)
  );

  tdlex_step u_step (
    .entry_i      (rd_entry),
    .miss_i       (p_miss_q),
    .char_i       (p_char_q),
    .eoi_i        (p_eoi_q),
    .cur_type_i   (type_q),
    .res_o        (step_res),
    .next_state_o (step_state),
    .next_type_o  (step_type)
  );

  // The lookup retires once the output register can take its result
  assign p_done = p_valid_q & (~out_valid_q | ~out_stall_i);

  always_comb begin
    p_valid_d = p_valid_q;
    if (char_xfer) begin
      p_valid_d = 1'b1;
    end else if (p_done) begin
      p_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (p_done) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      type_q      <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
      if (rst_xfer) begin
        state_q <= '0;
        type_q  <= '0;
      end else if (p_done) begin
        state_q <= step_state;
        type_q  <= step_type;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (char_xfer) begin
      p_char_q <= col;
      p_eoi_q  <= end_of_input_i;
      p_miss_q <= ~lookup_ok;
    end
    if (p_done) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_taken_o  = out_q.char_taken;
  assign append_char_o = out_q.append_char;
  assign out_char_o    = out_q.out_char;
  assign clear_token_o = out_q.clear_token;
  assign token_done_o  = out_q.token_done;
  assign token_type_o  = out_q.token_type;
  assign lex_error_o   = out_q.lex_error;
  assign input_ended_o = out_q.input_ended;

`ifndef SYNTHESIS
  // A result held in the stage is never dropped by a stalled output
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && out_valid_q && out_stall_i) |=> p_valid_q)
    else $error("lookup stage lost while output stalled");

  // A busy lookup stage blocks new transfers
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> in_stall_o)
    else $error("input taken while lookup pending");

  // Errors report an undefined type and a cleared token, never a finished one
  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && lex_error_o) |->
      (token_type_o == '0) && clear_token_o && !token_done_o)
    else $error("inconsistent error result");

  // The token type falls back to undefined after a finished token
  a_type_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_done && step_res.token_done) |=> (type_q == '0))
    else $error("token type kept after finished token");
`endif

endmodule

`default_nettype wire

// File: dv/tb_table_driven_lexer_fsm.sv
`timescale 1ns / 100ps

module tb_table_driven_lexer_fsm;

  // Codes with no name in the package
  localparam logic [1:0] CMD_NOP   = 2'd3;  // does nothing, gives no result
  localparam logic [1:0] BA_SPARE  = 2'd3;  // behaves as keep

  localparam int unsigned ROWS        = 16;
  localparam int unsigned COLS        = 256;
  localparam int unsigned RX_HOLD_CYC = 64;
  // clearing pass over 4096 entries plus ~1500 transfers at worst-case idling, many times over
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic [tdlex_pkg::CHAR_W-1:0]  char_t;
  typedef logic [tdlex_pkg::STATE_W-1:0] state_t;
  typedef logic [tdlex_pkg::TYPE_W-1:0]  ttype_t;

  typedef struct {
    logic [1:0] cmd;
    char_t      code;
    logic       eoi;
    state_t     row;
    logic [1:0] ca;
    logic [1:0] ba;
    logic       set_type;
    ttype_t     new_type;
    state_t     next_state;
  } lex_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // input channel, all known from time zero
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [1:0]          cmd_i           = tdlex_pkg::CMD_CHAR;
  char_t               char_code_i     = '0;
  logic                end_of_input_i  = 1'b0;
  state_t              entry_state_i   = '0;
  logic [1:0]          char_action_i   = '0;
  logic [1:0]          buffer_action_i = '0;
  logic                set_type_i      = 1'b0;
  ttype_t              new_type_i      = '0;
  state_t              next_state_i    = '0;

  // output channel
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic                char_taken_o;
  logic                append_char_o;
  char_t               out_char_o;
  logic                clear_token_o;
  logic                token_done_o;
  ttype_t              token_type_o;
  logic                lex_error_o;
  logic                input_ended_o;

  // stimulus and scoreboard
  lex_item_t           lex_item_q[$];
  tdlex_pkg::result_t  lex_result_q[$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned tx_idle_pct = 24;
  int unsigned rx_idle_pct = 73;
  int unsigned rx_hold_reqs = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  logic        in_took = 1'b0;

  // predictor state
  tdlex_pkg::entry_t act_table [ROWS][COLS];
  state_t            lex_state;
  ttype_t            lex_type;

  table_driven_lexer_fsm u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .char_code_i     (char_code_i),
    .end_of_input_i  (end_of_input_i),
    .entry_state_i   (entry_state_i),
    .char_action_i   (char_action_i),
    .buffer_action_i (buffer_action_i),
    .set_type_i      (set_type_i),
    .new_type_i      (new_type_i),
    .next_state_i    (next_state_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .char_taken_o    (char_taken_o),
    .append_char_o   (append_char_o),
    .out_char_o      (out_char_o),
    .clear_token_o   (clear_token_o),
    .token_done_o    (token_done_o),
    .token_type_o    (token_type_o),
    .lex_error_o     (lex_error_o),
    .input_ended_o   (input_ended_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Lexer predictor: one accepted transfer in, at most one expected result out.
  // ---------------------------------------------------------------------------
  task automatic apply_lex_item(lex_item_t it);
    tdlex_pkg::entry_t  e;
    tdlex_pkg::result_t r;
    char_t              ch;
    case (it.cmd)
      tdlex_pkg::CMD_WRITE: begin
        // every row, column and type fits the table at these widths
        act_table[it.row][it.code] = '{char_action: it.ca, buffer_action: it.ba,
                                       set_type: it.set_type, new_type: it.new_type,
                                       next_state: it.next_state};
      end
      tdlex_pkg::CMD_RESTART: begin
        lex_state = '0;
        lex_type  = '0;
      end
      tdlex_pkg::CMD_CHAR: begin
        ch = it.eoi ? tdlex_pkg::EOF_CODE : it.code;
        e  = act_table[lex_state][ch];
        r  = '0;
        r.char_taken  = 1'b1;
        r.input_ended = it.eoi;
        if (e.char_action == tdlex_pkg::CA_ERROR) begin
          // entry's buffer action, type and next state are dropped
          r.clear_token = 1'b1;
          r.lex_error   = 1'b1;
          lex_state     = '0;
          lex_type      = '0;
        end else begin
          if (e.char_action == tdlex_pkg::CA_ADD) begin
            r.append_char = 1'b1;
            r.out_char    = ch;
          end else if (e.char_action == tdlex_pkg::CA_PUTBACK && !it.eoi) begin
            r.char_taken = 1'b0;  // nothing to resend at end of input
          end
          if (e.buffer_action == tdlex_pkg::BA_CLEAR) r.clear_token = 1'b1;
          else if (e.buffer_action == tdlex_pkg::BA_RETURN) r.token_done = 1'b1;
          if (it.eoi) r.token_done = 1'b1;
          if (e.set_type) lex_type = e.new_type;
          lex_state = e.next_state;
        end
        r.token_type = lex_type;
        lex_result_q.insert(lex_result_q.size(), r);
        // finished token reports its type once, then falls back to undefined
        if (r.token_done) lex_type = '0;
      end
      default: ;  // CMD_NOP
    endcase
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. Results are checked
  // before the transfer of the same edge is predicted; a result never comes
  // out on the edge its transfer goes in.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    tdlex_pkg::result_t got;
    tdlex_pkg::result_t want;
    lex_item_t          seen;
    if (!rst_ni) begin
      for (int s = 0; s < ROWS; s++)
        for (int c = 0; c < COLS; c++)
          act_table[state_t'(s)][char_t'(c)] = tdlex_pkg::ERR_ENTRY;
      lex_state = '0;
      lex_type  = '0;
      in_took  <= 1'b0;
    end else begin
      in_took <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        got = '{char_taken_o, append_char_o, out_char_o, clear_token_o,
                token_done_o, token_type_o, lex_error_o, input_ended_o};
        if (lex_result_q.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = lex_result_q.pop_front();
          check_field("char_taken",  32'(want.char_taken),  32'(got.char_taken));
          check_field("append_char", 32'(want.append_char), 32'(got.append_char));
          check_field("out_char",    32'(want.out_char),    32'(got.out_char));
          check_field("clear_token", 32'(want.clear_token), 32'(got.clear_token));
          check_field("token_done",  32'(want.token_done),  32'(got.token_done));
          check_field("token_type",  32'(want.token_type),  32'(got.token_type));
          check_field("lex_error",   32'(want.lex_error),   32'(got.lex_error));
          check_field("input_ended", 32'(want.input_ended), 32'(got.input_ended));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        // predict from the payload actually presented
        seen = '{cmd_i, char_code_i, end_of_input_i, entry_state_i, char_action_i,
                 buffer_action_i, set_type_i, new_type_i, next_state_i};
        apply_lex_item(seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers the next item only when the line is free or the last one
  // transferred; the offer never looks at stall, and a held payload stays put.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drv
    lex_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (lex_item_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = lex_item_q.pop_front();
        cmd_i           <= nxt.cmd;
        char_code_i     <= nxt.code;
        end_of_input_i  <= nxt.eoi;
        entry_state_i   <= nxt.row;
        char_action_i   <= nxt.ca;
        buffer_action_i <= nxt.ba;
        set_type_i      <= nxt.set_type;
        new_type_i      <= nxt.new_type;
        next_state_i    <= nxt.next_state;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_reqs != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_reqs;
      rx_hold_left <= RX_HOLD_CYC;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_item(lex_item_t it);
    lex_item_q.insert(lex_item_q.size(), it);
  endtask

  // all fields random; callers pin the ones that matter
  function automatic lex_item_t rand_item(logic [1:0] cmd);
    lex_item_t it;
    it.cmd        = cmd;
    it.code       = char_t'($urandom_range(255));
    it.eoi        = 1'($urandom_range(1));
    it.row        = state_t'($urandom_range(15));
    it.ca         = 2'($urandom_range(3));
    it.ba         = 2'($urandom_range(3));
    it.set_type   = 1'($urandom_range(1));
    it.new_type   = ttype_t'($urandom_range(15));
    it.next_state = state_t'($urandom_range(15));
    return it;
  endfunction

  task automatic push_char(char_t code, logic eoi);
    lex_item_t it;
    it      = rand_item(tdlex_pkg::CMD_CHAR);
    it.code = code;
    it.eoi  = eoi;
    queue_item(it);
  endtask

  task automatic push_write(state_t row, char_t col,
                            logic [1:0] ca, logic [1:0] ba, logic st,
                            ttype_t nt, state_t ns);
    lex_item_t it;
    it            = rand_item(tdlex_pkg::CMD_WRITE);
    it.row        = row;
    it.code       = col;
    it.ca         = ca;
    it.ba         = ba;
    it.set_type   = st;
    it.new_type   = nt;
    it.next_state = ns;
    queue_item(it);
  endtask

  // A small dense lexer: 4 states x (5 chars + EOF column) all written, so the
  // character stream mostly walks real transitions instead of hitting errors.
  task automatic push_lexer_program(int n_chars);
    state_t      sts [4];
    char_t       cols [6];
    logic [1:0]  ca;
    int unsigned pick;
    sts[0] = '0;
    for (int i = 1; i < 4; i++) sts[2'(i)] = state_t'($urandom_range(15));
    for (int i = 0; i < 5; i++) cols[3'(i)] = char_t'($urandom_range(255));
    cols[5] = tdlex_pkg::EOF_CODE;
    for (int s = 0; s < 4; s++) begin
      for (int c = 0; c < 6; c++) begin
        if ($urandom_range(11) == 0) ca = tdlex_pkg::CA_ERROR;
        else ca = 2'($urandom_range(2));
        push_write(sts[2'(s)], cols[3'(c)], ca, 2'($urandom_range(3)),
                   1'($urandom_range(1)), ttype_t'($urandom_range(15)),
                   sts[2'($urandom_range(3))]);
      end
    end
    repeat (n_chars) begin
      pick = $urandom_range(99);
      if (pick < 80)      push_char(cols[3'($urandom_range(4))], 1'b0);
      else if (pick < 86) push_char(char_t'($urandom_range(255)), 1'b1);
      else if (pick < 92) push_char(char_t'($urandom_range(255)), 1'b0); // stray character
      else if (pick < 95) queue_item(rand_item(tdlex_pkg::CMD_RESTART));
      else if (pick < 97) queue_item(rand_item(CMD_NOP));
      else                queue_item(rand_item(tdlex_pkg::CMD_WRITE));  // stray entry
    end
  endtask

  // sender stays quiet until every expected result is back
  task automatic wait_drained();
    while (lex_item_q.size() != 0 || in_valid_i || lex_result_q.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stim
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: cleared table first
    push_char(8'h41, 1'b0);                                   // error from reset table
    push_char(8'h00, 1'b1);                                   // error at end of input
    // small hand-built lexer
    push_write(4'd0,  8'h61, tdlex_pkg::CA_ADD, tdlex_pkg::BA_KEEP,
               1'b1, 4'd5,  4'd1);
    push_write(4'd1,  8'h62, tdlex_pkg::CA_PUTBACK, tdlex_pkg::BA_RETURN,
               1'b0, 4'd0,  4'd0);
    push_write(4'd1,  8'hFF, tdlex_pkg::CA_IGNORE, tdlex_pkg::BA_CLEAR,
               1'b1, 4'd15, 4'd2);
    push_write(4'd2,  tdlex_pkg::EOF_CODE, tdlex_pkg::CA_ADD, BA_SPARE,
               1'b0, 4'd0,  4'd15);
    push_write(4'd15, tdlex_pkg::EOF_CODE, tdlex_pkg::CA_PUTBACK, tdlex_pkg::BA_KEEP,
               1'b0, 4'd3,  4'd0);
    push_write(4'd0,  tdlex_pkg::EOF_CODE, tdlex_pkg::CA_ERROR, tdlex_pkg::BA_RETURN,
               1'b1, 4'd9,  4'd7);
    push_char(8'h61, 1'b0);                                   // add, type set
    push_char(8'h62, 1'b0);                                   // put back + token done
    push_char(8'h61, 1'b0);
    push_char(8'hFF, 1'b0);                                   // ignore, clear, max type
    push_char(8'hAB, 1'b1);                                   // EOF adds, spare buf action
    push_char(8'h00, 1'b1);                                   // put back at EOF: taken
    push_char(8'h00, 1'b1);                                   // error entry, fields dropped
    push_char(8'h61, 1'b0);
    queue_item(rand_item(CMD_NOP));
    queue_item(rand_item(tdlex_pkg::CMD_RESTART));            // back to state 0, type 0
    push_char(8'h62, 1'b0);                                   // no rule in state 0
    push_char(8'h00, 1'b0);                                   // plain NUL uses EOF column
    push_char(8'h61, 1'b0);
    push_char(8'h62, 1'b0);

    // Random, phase 1: sender idles a little, receiver a lot
    repeat (5) push_lexer_program(76);
    wait_drained();

    // phase 2: the other way round
    tx_idle_pct = 73;
    rx_idle_pct = 24;
    repeat (5) push_lexer_program(76);
    wait_drained();

    // phase 3: no idling; a long receiver hold-off backs the block up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (5) push_lexer_program(76);
    rx_hold_reqs++;
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && lex_result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
